>>> sv/der2c_pkg.sv
// ----------------------------------------------------------------------------
// der2c_pkg : shared types and constants for the DER to compact converter
// Phase codes, status codes, the command word passed from the parser to the
// expander, and the sizing constants that follow from the component length.
// ----------------------------------------------------------------------------
package der2c_pkg;

  // bytes of one compact component (r or s)
  localparam int PART_BYTES = 32;
  localparam logic [7:0] PART_LEN = 8'(PART_BYTES);
  // width of a padding count 0..PART_BYTES
  localparam int PAD_W = $clog2(PART_BYTES + 1);

  // command queue depth, a power of two
  localparam int Q_DEPTH = 4;
  localparam int Q_AW = $clog2(Q_DEPTH);
  localparam int Q_CW = Q_AW + 1;

  // parse phase, one-hot
  typedef enum logic [7:0] {
    PH_HTAG  = 8'b0000_0001,
    PH_HLEN  = 8'b0000_0010,
    PH_RTAG  = 8'b0000_0100,
    PH_RLEN  = 8'b0000_1000,
    PH_RDATA = 8'b0001_0000,
    PH_STAG  = 8'b0010_0000,
    PH_SLEN  = 8'b0100_0000,
    PH_SDATA = 8'b1000_0000
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_TOOLONG  = 2'd2,
    ST_TRUNC    = 2'd3
  } status_t;

  // everything one input byte causes: zeros, then a data byte, then a status
  typedef struct packed {
    logic [PAD_W-1:0] pad;
    logic             has_data;
    logic [7:0]       data;
    logic             has_status;
    status_t          status;
  } cmd_t;

endpackage

>>> sv/der2c_front.sv
// ----------------------------------------------------------------------------
// der2c_front : DER parser
// Tracks the phase and lengths of the signature and turns each accepted byte
// into one command word for the expander.
// ----------------------------------------------------------------------------
module der2c_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        in_byte,
  input  logic              in_first,
  input  logic              in_last,
  output der2c_pkg::cmd_t   cmd,
  output logic              cmd_valid
);

  der2c_pkg::phase_t phase_r, phase_nxt, ph;
  logic [7:0] hlen_r, hlen_nxt, hl;
  logic [7:0] rlen_r, rlen_nxt, rl;
  logic [7:0] slen_r, slen_nxt, sl;
  logic [7:0] left_r, left_nxt, lf;
  logic       toolong_r, toolong_nxt, tl;
  logic [9:0] len_sum;
  logic [7:0] pad_full;

  always_comb begin
    // a first byte restarts from the reset state
    ph = in_first ? der2c_pkg::PH_HTAG : phase_r;
    hl = in_first ? 8'd0 : hlen_r;
    rl = in_first ? 8'd0 : rlen_r;
    sl = in_first ? 8'd0 : slen_r;
    lf = in_first ? 8'd0 : left_r;
    tl = in_first ? 1'b0 : toolong_r;

    phase_nxt   = ph;
    hlen_nxt    = hl;
    rlen_nxt    = rl;
    slen_nxt    = sl;
    left_nxt    = lf;
    toolong_nxt = tl;
    cmd         = '0;
    cmd.status  = der2c_pkg::ST_OK;
    pad_full    = der2c_pkg::PART_LEN - in_byte;

    case (ph)
      der2c_pkg::PH_HTAG: begin
        phase_nxt = der2c_pkg::PH_HLEN;
      end
      der2c_pkg::PH_HLEN: begin
        hlen_nxt  = in_byte;
        phase_nxt = der2c_pkg::PH_RTAG;
      end
      der2c_pkg::PH_RTAG: begin
        phase_nxt = der2c_pkg::PH_RLEN;
      end
      der2c_pkg::PH_RLEN: begin
        rlen_nxt = in_byte;
        left_nxt = in_byte;
        if (in_byte <= der2c_pkg::PART_LEN) begin
          cmd.pad = pad_full[der2c_pkg::PAD_W-1:0];
        end
        phase_nxt = (in_byte == 8'd0) ? der2c_pkg::PH_STAG : der2c_pkg::PH_RDATA;
      end
      der2c_pkg::PH_RDATA, der2c_pkg::PH_SDATA: begin
        if (ph == der2c_pkg::PH_RDATA || lf != 8'd0) begin
          // excess leading bytes are dropped and must be zero
          if (lf > der2c_pkg::PART_LEN) begin
            if (in_byte != 8'd0) begin
              toolong_nxt = 1'b1;
            end
          end else begin
            cmd.has_data = 1'b1;
            cmd.data     = in_byte;
          end
          left_nxt = lf - 8'd1;
          if (ph == der2c_pkg::PH_RDATA && lf == 8'd1) begin
            phase_nxt = der2c_pkg::PH_STAG;
          end
        end
      end
      der2c_pkg::PH_STAG: begin
        phase_nxt = der2c_pkg::PH_SLEN;
      end
      der2c_pkg::PH_SLEN: begin
        slen_nxt = in_byte;
        left_nxt = in_byte;
        if (in_byte <= der2c_pkg::PART_LEN) begin
          cmd.pad = pad_full[der2c_pkg::PAD_W-1:0];
        end
        phase_nxt = der2c_pkg::PH_SDATA;
      end
      default: begin
        phase_nxt = der2c_pkg::PH_HTAG;
      end
    endcase

    // status on the last byte; header mismatch wins over the rest
    len_sum = 10'd4 + {2'b00, rlen_nxt} + {2'b00, slen_nxt};
    if (in_last) begin
      cmd.has_status = 1'b1;
      if (phase_nxt == der2c_pkg::PH_SDATA && {2'b00, hlen_nxt} != len_sum) begin
        cmd.status = der2c_pkg::ST_MISMATCH;
      end else if (toolong_nxt) begin
        cmd.status = der2c_pkg::ST_TOOLONG;
      end else if (phase_nxt != der2c_pkg::PH_SDATA || left_nxt != 8'd0) begin
        cmd.status = der2c_pkg::ST_TRUNC;
      end else begin
        cmd.status = der2c_pkg::ST_OK;
      end
      phase_nxt   = der2c_pkg::PH_HTAG;
      hlen_nxt    = 8'd0;
      rlen_nxt    = 8'd0;
      slen_nxt    = 8'd0;
      left_nxt    = 8'd0;
      toolong_nxt = 1'b0;
    end
  end

  assign cmd_valid = (cmd.pad != '0) || cmd.has_data || cmd.has_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= der2c_pkg::PH_HTAG;
      hlen_r    <= 8'd0;
      rlen_r    <= 8'd0;
      slen_r    <= 8'd0;
      left_r    <= 8'd0;
      toolong_r <= 1'b0;
    end else if (acc) begin
      phase_r   <= phase_nxt;
      hlen_r    <= hlen_nxt;
      rlen_r    <= rlen_nxt;
      slen_r    <= slen_nxt;
      left_r    <= left_nxt;
      toolong_r <= toolong_nxt;
    end
  end

  // a last byte always leaves the parser back at the header tag
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_last |=> phase_r == der2c_pkg::PH_HTAG)
    else $error("parser not restarted after last byte");

  // every last byte yields a status command
  a_last_has_status: assert property (@(posedge clk) disable iff (!rst_n)
    in_last |-> cmd_valid && cmd.has_status)
    else $error("last byte without status");

  // the parser never sits in the r data phase with nothing left to take
  a_rdata_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == der2c_pkg::PH_RDATA |-> left_r != 8'd0)
    else $error("r data phase with empty count");

endmodule

>>> sv/der2c_cmdq.sv
// ----------------------------------------------------------------------------
// der2c_cmdq : command queue
// Short first-in first-out store of command words between parser and
// expander, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module der2c_cmdq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  der2c_pkg::cmd_t wr_cmd,
  input  logic            rd_en,
  output der2c_pkg::cmd_t rd_cmd,
  output logic            q_full,
  output logic            q_empty
);

  der2c_pkg::cmd_t               store_r [der2c_pkg::Q_DEPTH];
  logic [der2c_pkg::Q_AW-1:0]    wr_ptr_r;
  logic [der2c_pkg::Q_AW-1:0]    rd_ptr_r;
  logic [der2c_pkg::Q_CW-1:0]    cnt_r;
  logic                          do_wr, do_rd;

  assign q_full  = (cnt_r == der2c_pkg::Q_CW'(der2c_pkg::Q_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_cmd  = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // fill level agrees with the pointers
  a_cnt_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[der2c_pkg::Q_AW-1:0] == der2c_pkg::Q_AW'(wr_ptr_r - rd_ptr_r))
    else $error("queue count out of step with pointers");

  // a write without a read raises the level by one
  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    do_wr && !do_rd |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count not raised");

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= der2c_pkg::Q_CW'(der2c_pkg::Q_DEPTH))
    else $error("queue overfilled");

endmodule

>>> sv/der2c_back.sv
// ----------------------------------------------------------------------------
// der2c_back : result expander
// Holds one command word and hands it out as result words: padding zeros,
// then the data byte, then the status, one word per pop.
// ----------------------------------------------------------------------------
module der2c_back (
  input  logic            clk,
  input  logic            rst_n,
  input  der2c_pkg::cmd_t q_cmd,
  input  logic            q_empty,
  output logic            q_pop,
  input  logic            pop,
  output logic            empty,
  output logic [7:0]      out_byte,
  output logic            out_is_status,
  output logic [1:0]      out_status,
  output logic            out_end_of_run
);

  der2c_pkg::cmd_t cur_r;
  logic            busy_r;
  logic            pad_zero, last_word, adv, load;

  assign pad_zero  = (cur_r.pad == '0);
  assign last_word = (cur_r.pad == der2c_pkg::PAD_W'(1) && !cur_r.has_data
                      && !cur_r.has_status)
                  || (pad_zero && cur_r.has_data && !cur_r.has_status)
                  || (pad_zero && !cur_r.has_data && cur_r.has_status);
  assign adv   = busy_r && pop;
  assign load  = !busy_r || (adv && last_word);
  assign q_pop = load && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cur_r  <= '0;
    end else if (load) begin
      busy_r <= !q_empty;
      if (!q_empty) begin
        cur_r <= q_cmd;
      end
    end else if (adv) begin
      if (!pad_zero) begin
        cur_r.pad <= cur_r.pad - 1'b1;
      end else if (cur_r.has_data) begin
        cur_r.has_data <= 1'b0;
      end else begin
        cur_r.has_status <= 1'b0;
      end
    end
  end

  assign empty          = !busy_r;
  assign out_byte       = (pad_zero && cur_r.has_data) ? cur_r.data : 8'd0;
  assign out_is_status  = pad_zero && !cur_r.has_data && cur_r.has_status;
  assign out_status     = out_is_status ? cur_r.status : der2c_pkg::ST_OK;
  assign out_end_of_run = last_word;

  // a status word always closes its run
  a_status_ends: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_is_status |-> out_end_of_run)
    else $error("status word not at end of run");

  // words of one run follow without a gap
  a_run_holds: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !empty && !out_end_of_run |=> !empty)
    else $error("run broken before its end");

  // a held word never carries nothing
  a_busy_work: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !pad_zero || cur_r.has_data || cur_r.has_status)
    else $error("expander holds an empty command");

endmodule

>>> sv/der_signature_to_compact.sv
// ----------------------------------------------------------------------------
// der_signature_to_compact : DER ECDSA signature to 64-byte compact form
// Parses a DER signature one byte per word and emits r then s, each
// left-padded with zeros to 32 bytes, followed by a status word.
// ----------------------------------------------------------------------------
//
//  channel  handshake      words carried
//  -------  -------------  -----------------------------------------------
//  input    push / full    in_byte, in_first_byte, in_last_byte
//  result   pop / empty    out_byte, out_is_status, out_status,
//                          out_end_of_run
//
// one input word is taken per cycle while the command queue (4 commands) has room
// a length byte can cause up to 32 padding words and a last byte one status word;
// results leave one word per popped cycle, so padding bursts fill the queue and stall input
// with the expander idle, a taken word is queued, then loaded to show its first result
// reset (rst_n low at a clock edge) empties the queue and restarts parsing
// a stalled pop leaves the result ports steady; input flows on until the queue is full
//
module der_signature_to_compact (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_first_byte,
  input  logic       in_last_byte,
  // result channel
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       out_is_status,
  output logic [1:0] out_status,
  output logic       out_end_of_run
);

  der2c_pkg::cmd_t front_cmd;
  der2c_pkg::cmd_t head_cmd;
  logic            front_valid;
  logic            acc;
  logic            q_full, q_empty, q_pop;

  // a word is taken whenever the queue has room, even one that yields nothing
  assign full = q_full;
  assign acc  = push && !q_full;

  der2c_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .in_byte   (in_byte),
    .in_first  (in_first_byte),
    .in_last   (in_last_byte),
    .cmd       (front_cmd),
    .cmd_valid (front_valid)
  );

  // only words that produce results go into the queue
  der2c_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (acc && front_valid),
    .wr_cmd  (front_cmd),
    .rd_en   (q_pop),
    .rd_cmd  (head_cmd),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  der2c_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_cmd          (head_cmd),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .out_byte       (out_byte),
    .out_is_status  (out_is_status),
    .out_status     (out_status),
    .out_end_of_run (out_end_of_run)
  );

endmodule
